@@ sv/ffha_pkg.sv @@
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 25;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = 25'h1000000;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_IGNORE = 2'd2
  } op_t;

  typedef enum logic {
    CFG_HEAP_START = 1'b0,
    CFG_HEAP_SIZE  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] req_bytes;
    logic [ADDR_W-1:0] rel_addr;
  } work_t;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_start;
    logic [SIZE_W-1:0] heap_size;
  } heap_cfg_t;

endpackage

@@ sv/ffha_req_if.sv @@
// request channel of the allocator
interface ffha_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [ffha_pkg::SIZE_W-1:0]  request_bytes;
  logic [ffha_pkg::ADDR_W-1:0]  release_address;

  modport source (output valid, command, request_bytes, release_address, input ready);
  modport sink   (input valid, command, request_bytes, release_address, output ready);
endinterface

@@ sv/ffha_rsp_if.sv @@
// result channel of the allocator
interface ffha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffha_pkg::ADDR_W-1:0]  payload_address;
  logic [2:0]                   status;

  modport source (output valid, payload_address, status, input ready);
  modport sink   (input valid, payload_address, status, output ready);
endinterface

@@ sv/ffha_front.sv @@
// request intake and classification into allocate, free or ignored
module ffha_front (
  ffha_req_if.sink         in_if,
  input  logic             q_full,
  output logic             q_push,
  output ffha_pkg::work_t  q_push_ent
);

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    q_push_ent.req_bytes = in_if.request_bytes;
    q_push_ent.rel_addr  = in_if.release_address;
    if (ffha_pkg::cmd_t'(in_if.command) == ffha_pkg::CMD_ALLOC) begin
      q_push_ent.op = (in_if.request_bytes == '0) ? ffha_pkg::OP_IGNORE : ffha_pkg::OP_ALLOC;
    end else begin
      q_push_ent.op = (in_if.release_address == '0) ? ffha_pkg::OP_IGNORE : ffha_pkg::OP_FREE;
    end
  end

endmodule

@@ sv/ffha_queue.sv @@
// short request queue between front and back
module ffha_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ffha_pkg::work_t  push_ent,
  output logic             full,
  input  logic             pop,
  output logic             pop_vld,
  output ffha_pkg::work_t  pop_ent
);

  localparam int unsigned PW = $clog2(ffha_pkg::Q_DEPTH);
  localparam int unsigned CW = $clog2(ffha_pkg::Q_DEPTH + 1);

  ffha_pkg::work_t ent_r [ffha_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full    = (cnt_r == CW'(ffha_pkg::Q_DEPTH));
  assign pop_vld = (cnt_r != '0);
  assign pop_ent = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

@@ sv/ffha_back.sv @@
// block table scan, reuse, bump carve and result register
module ffha_back #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffha_pkg::heap_cfg_t  cfg,
  input  logic                 q_vld,
  input  ffha_pkg::work_t      q_ent,
  output logic                 q_pop,
  ffha_rsp_if.source           out_if
);

  localparam int unsigned SW = ffha_pkg::SIZE_W;
  localparam int unsigned AW = ffha_pkg::ADDR_W;
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned NW = SW + 2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic [SW-1:0] off;
    logic [SW-1:0] bytes;
    logic          is_free;
  } blk_t;

  blk_t                mem [MAX_BLOCKS];
  blk_t                rdata_r;
  logic                mem_we;
  logic                mem_re;
  logic [IW-1:0]       mem_waddr;
  blk_t                mem_wdata;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SW-1:0]       bump_r, bump_nxt;
  logic [CW-1:0]       scan_idx_r, scan_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  ffha_pkg::op_t       op_r, op_nxt;
  logic [SW-1:0]       req_r, req_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [NW-1:0]       need_r, need_nxt;

  logic                out_vld_r;
  logic [AW-1:0]       out_addr_r;
  ffha_pkg::status_t   out_stat_r;

  logic                start;
  logic                hit;
  logic                scan_end;
  logic                tbl_full;
  logic [AW-1:0]       blk_addr;
  logic [SW-1:0]       carve_off;
  logic [AW-1:0]       carve_addr;
  logic                res_ld;
  logic [AW-1:0]       res_addr;
  ffha_pkg::status_t   res_stat;

  assign start      = (state_r == S_IDLE) && q_vld && (!out_vld_r || out_if.ready);
  assign q_pop      = start;
  assign blk_addr   = cfg.heap_start + {{(AW-SW){1'b0}}, rdata_r.off};
  assign carve_off  = bump_r + SW'(HEADER_BYTES);
  assign carve_addr = cfg.heap_start + {{(AW-SW){1'b0}}, carve_off};
  assign tbl_full   = (count_r == CW'(MAX_BLOCKS));
  assign scan_end   = !cmp_vld_r && (scan_idx_r == count_r);
  assign hit        = cmp_vld_r &&
                      ((op_r == ffha_pkg::OP_ALLOC) ? (rdata_r.is_free && (rdata_r.bytes >= req_r))
                                                    : (blk_addr == addr_r));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    bump_nxt     = bump_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    op_nxt       = op_r;
    req_nxt      = req_r;
    addr_nxt     = addr_r;
    need_nxt     = need_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cmp_idx_r;
    mem_wdata    = rdata_r;
    res_ld       = 1'b0;
    res_addr     = '0;
    res_stat     = ffha_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt       = q_ent.op;
          req_nxt      = q_ent.req_bytes;
          addr_nxt     = q_ent.rel_addr;
          need_nxt     = NW'(bump_r) + NW'(HEADER_BYTES) + NW'(q_ent.req_bytes);
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          if (q_ent.op == ffha_pkg::OP_IGNORE) begin
            res_ld   = 1'b1;
            res_stat = ffha_pkg::ST_IGNORED;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_we            = 1'b1;
          mem_waddr         = cmp_idx_r;
          mem_wdata.is_free = (op_r == ffha_pkg::OP_FREE);
          res_ld            = 1'b1;
          res_addr          = (op_r == ffha_pkg::OP_ALLOC) ? blk_addr : '0;
          cmp_vld_nxt       = 1'b0;
          state_nxt         = S_IDLE;
        end else if (scan_end) begin
          res_ld    = 1'b1;
          state_nxt = S_IDLE;
          if (op_r == ffha_pkg::OP_FREE) begin
            res_stat = ffha_pkg::ST_UNKNOWN;
          end else if (need_r > NW'(cfg.heap_size)) begin
            res_stat = ffha_pkg::ST_EXHAUSTED;
          end else if (tbl_full) begin
            res_stat = ffha_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count_r[IW-1:0];
            mem_wdata = '{off: carve_off, bytes: req_r, is_free: 1'b0};
            count_nxt = count_r + CW'(1);
            bump_nxt  = need_r[SW-1:0];
            res_addr  = carve_addr;
          end
        end else if (scan_idx_r != count_r) begin
          mem_re       = 1'b1;
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[IW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // block table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[scan_idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      bump_r     <= '0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      bump_r     <= bump_nxt;
      scan_idx_r <= scan_idx_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      if (res_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    op_r      <= op_nxt;
    req_r     <= req_nxt;
    addr_r    <= addr_nxt;
    need_r    <= need_nxt;
    if (res_ld) begin
      out_addr_r <= res_addr;
      out_stat_r <= res_stat;
    end
  end

  assign out_if.valid           = out_vld_r;
  assign out_if.payload_address = out_addr_r;
  assign out_if.status          = out_stat_r;

endmodule

@@ sv/first_fit_heap_allocator.sv @@
// first-fit heap allocator top level
// Each request returns one result in order. Zero-size allocates and null frees
// pass the back end without a table scan. Other requests scan the block table
// once, one read per cycle from the single read port of the table memory, with
// the compare in the cycle after each read. A two-entry queue takes new requests
// while the back end works and a result waits in the output register. The
// table needs no clearing after reset; only entries below the block count are read.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ffha_req_if.sink                     in_if,
  ffha_rsp_if.source                   out_if,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0]  cfg_wdata
);

  ffha_pkg::heap_cfg_t cfg_r;
  logic                q_push;
  logic                q_full;
  ffha_pkg::work_t     q_push_ent;
  logic                q_pop;
  logic                q_vld;
  ffha_pkg::work_t     q_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heap_start <= '0;
      cfg_r.heap_size  <= ffha_pkg::HEAP_SIZE_RST;
    end else if (cfg_we) begin
      unique case (ffha_pkg::cfg_idx_t'(cfg_index))
        ffha_pkg::CFG_HEAP_START: cfg_r.heap_start <= cfg_wdata;
        ffha_pkg::CFG_HEAP_SIZE:  cfg_r.heap_size  <= cfg_wdata[ffha_pkg::SIZE_W-1:0];
        default:                  cfg_r            <= cfg_r;
      endcase
    end
  end

  ffha_front u_front (
    .in_if      (in_if),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_ent (q_push_ent)
  );

  ffha_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .pop_vld  (q_vld),
    .pop_ent  (q_ent)
  );

  ffha_back #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_vld  (q_vld),
    .q_ent  (q_ent),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

endmodule

@@ sv/ffha_checker.sv @@
// port-level checks of the allocator and their binding to the top level
module ffha_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ffha_pkg::ADDR_W-1:0]  payload_address,
  input logic [2:0]                   status
);

  logic [3:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests accepted and not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pend_r <= pend_r + 4'd1;
        2'b01:   pend_r <= pend_r - 4'd1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_address))
    else $error("result changed while stalled");

  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ffha_pkg::ST_OK) |-> (payload_address == '0))
    else $error("failed request carries an address");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (pend_r != '0))
    else $error("result without a pending request");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .payload_address (out_if.payload_address),
  .status          (out_if.status)
);
